// ===== design/mdm_pkg.sv =====
package mdm_pkg;

	localparam int DEF_QUEUE_COUNT = 256;
	localparam int DEF_POOL_NODES  = 4096;

	localparam logic [30:0] MODULUS    = 31'd1000000007;
	localparam logic [30:0] MODULUS_X2 = 31'd2000000014;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_POP_FRONT  = 3'd1,
		OP_PUSH_BACK  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_ADD_ALL    = 3'd4,
		OP_APPEND     = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_SAME  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		K_NOP,
		K_SAME,
		K_PUSH,
		K_POP,
		K_ADD,
		K_APPEND
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic        at_back;
		logic [7:0]  q;
		logic [7:0]  r;
		logic [29:0] value;
	} cmd_t;

	typedef struct packed {
		logic [29:0] pop_value;
		status_t     status;
	} res_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_QRD,
		S_PUSH_LINK,
		S_POP_WB,
		S_ADD_WR,
		S_APP_R,
		S_APP_W2,
		S_DONE
	} state_t;

endpackage

// ===== design/multi_deque_manager.sv =====
// Many double-ended queues sharing one pool of POOL_NODES linked nodes. A request
// names push or pop at either end, add-to-all (mod 1000000007) or append of one
// queue onto another; each request yields exactly one result (popped value and a
// status). After reset a clearing pass zeroes the queue lengths; full stays high
// until it ends. Requests are taken into a two-entry queue and executed one at a
// time by a sequencer on memories with one read and one write port. Each request
// first reads its queue entry. A push then links the new node to its neighbour and
// a pop writes back the queue entry, neither when the queue is empty or (for a
// push) the pool is full. An append reads the other queue and writes both, stopping
// early when it is empty; add-to-all reads one node and writes one each cycle.
// Ignored requests and self-appends go straight to the result. A finished result
// waits in an output register so the next request can start while it is unread.
module multi_deque_manager #(
	parameter int QUEUE_COUNT = mdm_pkg::DEF_QUEUE_COUNT,
	parameter int POOL_NODES  = mdm_pkg::DEF_POOL_NODES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  op,
	input  logic [7:0]  queue_index,
	input  logic [7:0]  other_queue,
	input  logic [29:0] value,
	output logic        empty,
	input  logic        pop,
	output logic [29:0] pop_value,
	output logic [1:0]  status
);
	import mdm_pkg::*;

	logic  front_full;
	logic  cmd_valid;
	cmd_t  cmd;
	logic  cmd_take;
	logic  res_valid;
	res_t  res;
	logic  res_ready;
	logic  clearing;
	logic  out_valid_q;
	res_t  out_q;

	// front: accept and classify requests
	mdm_front #(
		.QUEUE_COUNT(QUEUE_COUNT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push && !clearing),
		.full       (front_full),
		.op         (op),
		.queue_index(queue_index),
		.other_queue(other_queue),
		.value      (value),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_take   (cmd_take)
	);

	// back: walk the lists and update the pool
	mdm_back #(
		.QUEUE_COUNT(QUEUE_COUNT),
		.POOL_NODES (POOL_NODES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_take (cmd_take),
		.res_valid(res_valid),
		.res      (res),
		.res_ready(res_ready),
		.clearing (clearing)
	);

	// hold requests off while the queue table is being cleared
	assign full = front_full || clearing;

	// output register: advance when empty or being drained this cycle
	assign res_ready = !out_valid_q || pop;
	assign empty     = !out_valid_q;
	assign pop_value = out_q.pop_value;
	assign status    = out_q.status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready)
			out_q <= res;
	end

	// a stalled result must be held by the back end
	a_hold_res: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result dropped while stalled");

	// only a successful pop carries a value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && status != ST_OK |-> pop_value == 30'd0)
		else $error("failed request returned a value");

	// nothing may come out of the clearing pass
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clearing) |-> empty && !cmd_valid)
		else $error("result pending at end of clearing");

	// the sequencer takes no request while clearing
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !cmd_take && !res_valid)
		else $error("request taken during clearing");

endmodule

// ===== design/mdm_front.sv =====
module mdm_front #(
	parameter int QUEUE_COUNT = mdm_pkg::DEF_QUEUE_COUNT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [2:0]    op,
	input  logic [7:0]    queue_index,
	input  logic [7:0]    other_queue,
	input  logic [29:0]   value,
	output logic          cmd_valid,
	output mdm_pkg::cmd_t cmd,
	input  logic          cmd_take
);
	import mdm_pkg::*;

	cmd_t       cmd_in;
	cmd_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;
	logic       acc;

	// classify the request
	always_comb begin
		cmd_in.kind    = K_NOP;
		cmd_in.at_back = (op_t'(op) == OP_PUSH_BACK) || (op_t'(op) == OP_POP_BACK);
		cmd_in.q       = queue_index;
		cmd_in.r       = other_queue;
		cmd_in.value   = value;
		if (32'(queue_index) < QUEUE_COUNT) begin
			unique case (op_t'(op))
				OP_PUSH_FRONT, OP_PUSH_BACK: cmd_in.kind = K_PUSH;
				OP_POP_FRONT, OP_POP_BACK:   cmd_in.kind = K_POP;
				OP_ADD_ALL:                  cmd_in.kind = K_ADD;
				OP_APPEND: begin
					if (32'(other_queue) < QUEUE_COUNT)
						cmd_in.kind = (queue_index == other_queue) ? K_SAME : K_APPEND;
				end
				default: cmd_in.kind = K_NOP;
			endcase
		end
	end

	assign full      = (count_q == 2'd2);
	assign acc       = push && !full;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (acc)
				wr_q <= ~wr_q;
			if (cmd_take)
				rd_q <= ~rd_q;
			case ({acc, cmd_take})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc)
			slot_q[wr_q] <= cmd_in;
	end

endmodule

// ===== design/mdm_back.sv =====
module mdm_back #(
	parameter int QUEUE_COUNT = mdm_pkg::DEF_QUEUE_COUNT,
	parameter int POOL_NODES  = mdm_pkg::DEF_POOL_NODES
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  mdm_pkg::cmd_t cmd,
	output logic          cmd_take,
	output logic          res_valid,
	output mdm_pkg::res_t res,
	input  logic          res_ready,
	output logic          clearing
);
	import mdm_pkg::*;

	localparam int NW = $clog2(POOL_NODES);
	localparam int QW = $clog2(QUEUE_COUNT);
	localparam int LW = NW + 1;

	typedef struct packed {
		logic [NW-1:0] head;
		logic [NW-1:0] tail;
		logic [LW-1:0] len;
	} qent_t;

	qent_t       qmem [QUEUE_COUNT];
	logic [29:0] nval_mem [POOL_NODES];
	logic [NW-1:0] nnext_mem [POOL_NODES];
	logic [NW-1:0] nprev_mem [POOL_NODES];

	state_t        state_q, state_d;
	cmd_t          cmd_q;
	qent_t         qent_q;
	qent_t         qrd_q;
	logic [29:0]   nval_rd_q;
	logic [NW-1:0] nnext_rd_q;
	logic [NW-1:0] nprev_rd_q;
	logic [NW-1:0] node_q;
	logic [NW-1:0] cur_q;
	logic [LW-1:0] cnt_q;
	logic [NW-1:0] free_head_q;
	logic [LW-1:0] free_len_q;
	logic [LW-1:0] fresh_q;
	logic [QW-1:0] clr_idx_q;
	res_t          res_q;

	logic [QW-1:0] q_raddr, q_waddr;
	logic          q_we;
	qent_t         q_wdata;
	logic [NW-1:0] n_raddr;
	logic          nv_we, nn_we, np_we;
	logic [NW-1:0] nv_waddr, nn_waddr, np_waddr;
	logic [29:0]   nv_wdata;
	logic [NW-1:0] nn_wdata, np_wdata;

	logic [QW-1:0] qi, ri;
	logic          from_free, pool_full;
	logic [NW-1:0] new_node, pop_node;
	logic [30:0]   sum;
	logic [29:0]   add_res;

	assign qi        = QW'(cmd_q.q);
	assign ri        = QW'(cmd_q.r);
	assign from_free = (free_len_q != '0);
	assign pool_full = !from_free && !(fresh_q < LW'(POOL_NODES));
	assign new_node  = from_free ? free_head_q : fresh_q[NW-1:0];
	assign pop_node  = cmd_q.at_back ? qrd_q.tail : qrd_q.head;
	assign sum       = {1'b0, nval_rd_q} + {1'b0, cmd_q.value};

	always_comb begin
		if (sum >= MODULUS_X2)
			add_res = 30'(sum - MODULUS_X2);
		else if (sum >= MODULUS)
			add_res = 30'(sum - MODULUS);
		else
			add_res = sum[29:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR:
				if (clr_idx_q == QW'(QUEUE_COUNT - 1))
					state_d = S_IDLE;
			S_IDLE:
				if (cmd_valid)
					state_d = (cmd.kind == K_NOP || cmd.kind == K_SAME) ? S_DONE : S_QRD;
			S_QRD: begin
				case (cmd_q.kind)
					K_PUSH:   state_d = (pool_full || qrd_q.len == '0) ? S_DONE : S_PUSH_LINK;
					K_POP:    state_d = (qrd_q.len == '0) ? S_DONE : S_POP_WB;
					K_ADD:    state_d = (qrd_q.len == '0) ? S_DONE : S_ADD_WR;
					K_APPEND: state_d = S_APP_R;
					default:  state_d = S_DONE;
				endcase
			end
			S_PUSH_LINK: state_d = S_DONE;
			S_POP_WB:    state_d = S_DONE;
			S_ADD_WR:    state_d = (cnt_q == LW'(1)) ? S_DONE : S_ADD_WR;
			S_APP_R:     state_d = (qrd_q.len == '0) ? S_DONE : S_APP_W2;
			S_APP_W2:    state_d = S_DONE;
			S_DONE:      state_d = res_ready ? S_IDLE : S_DONE;
			default:     state_d = S_IDLE;
		endcase
	end

	// memory controls and handshakes
	always_comb begin
		cmd_take  = 1'b0;
		res_valid = 1'b0;
		clearing  = 1'b0;
		q_raddr   = QW'(cmd.q);
		n_raddr   = free_head_q;
		q_we      = 1'b0;
		q_waddr   = qi;
		q_wdata   = '0;
		nv_we     = 1'b0;
		nv_waddr  = new_node;
		nv_wdata  = cmd_q.value;
		nn_we     = 1'b0;
		nn_waddr  = new_node;
		nn_wdata  = '0;
		np_we     = 1'b0;
		np_waddr  = new_node;
		np_wdata  = '0;
		unique case (state_q)
			S_CLEAR: begin
				clearing = 1'b1;
				q_we     = 1'b1;
				q_waddr  = clr_idx_q;
			end
			S_IDLE: cmd_take = cmd_valid;
			S_QRD: begin
				case (cmd_q.kind)
					K_PUSH: begin
						if (!pool_full) begin
							nv_we    = 1'b1;
							nn_we    = 1'b1;
							np_we    = 1'b1;
							nn_wdata = (qrd_q.len == '0 || cmd_q.at_back) ? '0 : qrd_q.head;
							np_wdata = (qrd_q.len != '0 && cmd_q.at_back) ? qrd_q.tail : '0;
							q_we     = 1'b1;
							q_wdata.len = qrd_q.len + LW'(1);
							if (qrd_q.len == '0) begin
								q_wdata.head = new_node;
								q_wdata.tail = new_node;
							end else if (cmd_q.at_back) begin
								q_wdata.head = qrd_q.head;
								q_wdata.tail = new_node;
							end else begin
								q_wdata.head = new_node;
								q_wdata.tail = qrd_q.tail;
							end
						end
					end
					K_POP:    n_raddr = pop_node;
					K_ADD:    n_raddr = qrd_q.head;
					K_APPEND: q_raddr = ri;
					default: ;
				endcase
			end
			S_PUSH_LINK: begin
				if (cmd_q.at_back) begin
					nn_we    = 1'b1;
					nn_waddr = qent_q.tail;
					nn_wdata = node_q;
				end else begin
					np_we    = 1'b1;
					np_waddr = qent_q.head;
					np_wdata = node_q;
				end
			end
			S_POP_WB: begin
				q_we        = 1'b1;
				q_wdata     = qent_q;
				q_wdata.len = qent_q.len - LW'(1);
				if (qent_q.len != LW'(1)) begin
					if (cmd_q.at_back)
						q_wdata.tail = nprev_rd_q;
					else
						q_wdata.head = nnext_rd_q;
				end
				nn_we    = 1'b1;
				nn_waddr = node_q;
				nn_wdata = free_head_q;
			end
			S_ADD_WR: begin
				nv_we    = 1'b1;
				nv_waddr = cur_q;
				nv_wdata = add_res;
				n_raddr  = nnext_rd_q;
			end
			S_APP_R: begin
				if (qrd_q.len != '0) begin
					if (qent_q.len != '0) begin
						nn_we    = 1'b1;
						nn_waddr = qent_q.tail;
						nn_wdata = qrd_q.head;
						np_we    = 1'b1;
						np_waddr = qrd_q.head;
						np_wdata = qent_q.tail;
					end
					q_we         = 1'b1;
					q_wdata.head = (qent_q.len == '0) ? qrd_q.head : qent_q.head;
					q_wdata.tail = qrd_q.tail;
					q_wdata.len  = qent_q.len + qrd_q.len;
				end
			end
			S_APP_W2: begin
				q_we    = 1'b1;
				q_waddr = ri;
			end
			S_DONE: res_valid = 1'b1;
			default: ;
		endcase
	end

	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_idx_q   <= '0;
			free_head_q <= '0;
			free_len_q  <= '0;
			fresh_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR)
				clr_idx_q <= clr_idx_q + QW'(1);
			if (state_q == S_QRD && cmd_q.kind == K_PUSH && !pool_full) begin
				if (from_free) begin
					free_head_q <= nnext_rd_q;
					free_len_q  <= free_len_q - LW'(1);
				end else begin
					fresh_q <= fresh_q + LW'(1);
				end
			end
			if (state_q == S_POP_WB) begin
				free_head_q <= node_q;
				free_len_q  <= free_len_q + LW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd_q            <= cmd;
					res_q.pop_value  <= '0;
					res_q.status     <= (cmd.kind == K_SAME) ? ST_SAME : ST_OK;
				end
			end
			S_QRD: begin
				qent_q <= qrd_q;
				node_q <= (cmd_q.kind == K_PUSH) ? new_node : pop_node;
				cur_q  <= qrd_q.head;
				cnt_q  <= qrd_q.len;
				if (cmd_q.kind == K_PUSH && pool_full)
					res_q.status <= ST_FULL;
				if (cmd_q.kind == K_POP && qrd_q.len == '0)
					res_q.status <= ST_EMPTY;
			end
			S_POP_WB: res_q.pop_value <= nval_rd_q;
			S_ADD_WR: begin
				cur_q <= nnext_rd_q;
				cnt_q <= cnt_q - LW'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_we)
			qmem[q_waddr] <= q_wdata;
		qrd_q <= qmem[q_raddr];
	end

	always_ff @(posedge clk) begin
		if (nv_we)
			nval_mem[nv_waddr] <= nv_wdata;
		nval_rd_q <= nval_mem[n_raddr];
	end

	always_ff @(posedge clk) begin
		if (nn_we)
			nnext_mem[nn_waddr] <= nn_wdata;
		nnext_rd_q <= nnext_mem[n_raddr];
	end

	always_ff @(posedge clk) begin
		if (np_we)
			nprev_mem[np_waddr] <= np_wdata;
		nprev_rd_q <= nprev_mem[n_raddr];
	end

endmodule
